>>> sv/lags_pkg.sv
// ----------------------------------------------------------------------------
// lags_pkg - shared constants and types for the life generation stream
// Grid limits, field widths, register map and the pipeline stage word.
// ----------------------------------------------------------------------------
`default_nettype none

package lags_pkg;

    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 4096;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);    // column index bits
    localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);   // row index bits
    localparam int unsigned GW_W  = COL_W + 1;            // grid_width register bits
    localparam int unsigned GH_W  = ROW_W + 1;            // grid_height register bits

    localparam int unsigned APB_DW = 32;
    localparam int unsigned APB_AW = 3;

    localparam logic [GW_W-1:0] GRID_WIDTH_RST  = GW_W'(10);
    localparam logic [GH_W-1:0] GRID_HEIGHT_RST = GH_W'(10);
    localparam logic [GW_W-1:0] GW_MIN = GW_W'(3);
    localparam logic [GH_W-1:0] GH_MIN = GH_W'(3);
    localparam logic [GW_W-1:0] GW_MAX = GW_W'(MAX_WIDTH);
    localparam logic [GH_W-1:0] GH_MAX = GH_W'(MAX_HEIGHT);

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } t_reg_idx;

    // line memory word: {upper row cell, middle row cell}
    localparam int unsigned LINE_W = 2;

    typedef struct packed {
        logic             alive;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row_out;
        logic [COL_W-1:0] col_out;
        logic             emit;
        logic             last;
    } t_stage;

endpackage

`default_nettype wire

>>> sv/lags_in_if.sv
// ----------------------------------------------------------------------------
// lags_in_if - raster cell channel
// One word per padded grid cell: live state and start-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface lags_in_if;
    logic valid;
    logic ready;
    logic cell_alive;
    logic frame_start;

    modport source (output valid, output cell_alive, output frame_start, input ready);
    modport sink   (input valid, input cell_alive, input frame_start, output ready);
endinterface

`default_nettype wire

>>> sv/lags_out_if.sv
// ----------------------------------------------------------------------------
// lags_out_if - next generation result channel
// One word per interior cell: next state, padded position, end-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface lags_out_if import lags_pkg::*; ;
    logic             valid;
    logic             ready;
    logic             next_alive;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic             last_of_frame;

    modport source (output valid, output next_alive, output cell_row, output cell_col,
                    output last_of_frame, input ready);
    modport sink   (input valid, input next_alive, input cell_row, input cell_col,
                    input last_of_frame, output ready);
endinterface

`default_nettype wire

>>> sv/life_automaton_generation_stream.sv
// The edge that accepts an interior cell's lower-right neighbour reads the line memory
//   into stage 1; the result word loads into the output register as stage 1 moves.
// Throughput: one cell per cycle, one line memory read and one write per cell; input
//   ready drops only while stage 1 holds a result word behind a full output register.
// Reset (synchronous, active low): counters, window, stage and output valid flags
//   clear, grid_width and grid_height return to 10; the line memory is not cleared.
// ----------------------------------------------------------------------------
// life_automaton_generation_stream - one B3/S23 generation over a raster stream
// A line memory keeps the two rows above the arriving cell, a 3x3 window
// counts neighbours and each interior cell's next state leaves with its place.
// ----------------------------------------------------------------------------
`default_nettype none

module life_automaton_generation_stream import lags_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    lags_in_if.sink                i_in,
    lags_out_if.source             o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GW_W-1:0] r_grid_width;
    logic [GH_W-1:0] r_grid_height;
    logic [GW_W-1:0] w_use;
    logic [GH_W-1:0] h_use;
    t_reg_idx        reg_idx;
    logic            cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[GW_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[GH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GRID_WIDTH:  prdata = APB_DW'(r_grid_width);
            REG_GRID_HEIGHT: prdata = APB_DW'(r_grid_height);
            default:         prdata = '0;
        endcase
    end

    // Limit the dimensions in use to the supported range
    always_comb begin
        if (r_grid_width < GW_MIN) begin
            w_use = GW_MIN;
        end else if (r_grid_width > GW_MAX) begin
            w_use = GW_MAX;
        end else begin
            w_use = r_grid_width;
        end
        if (r_grid_height < GH_MIN) begin
            h_use = GH_MIN;
        end else if (r_grid_height > GH_MAX) begin
            h_use = GH_MAX;
        end else begin
            h_use = r_grid_height;
        end
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    t_stage r_s1;
    logic   r_s1_valid;
    logic   r_out_valid;
    logic   s1_move;
    logic   in_accept;
    logic   out_load;

    // Stage 1 moves unless it has a word to deliver and the output is full
    assign s1_move   = r_s1_valid && (!r_s1.emit || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_move;
    assign in_accept = i_in.valid && i_in.ready;
    assign out_load  = s1_move && r_s1.emit;

    // ------------------------------------------------------------------
    // Stage 0: raster position of the arriving cell
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [GW_W-1:0]  col_ext;
    logic [GH_W-1:0]  row_ext;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    t_stage           n_s1;

    assign col_cur = i_in.frame_start ? '0 : r_col;
    assign row_cur = i_in.frame_start ? '0 : r_row;
    assign col_ext = GW_W'(col_cur);
    assign row_ext = GH_W'(row_cur);

    always_comb begin
        // wrap the column at the row end, the row at the frame end
        if (col_ext + GW_W'(1) >= w_use) begin
            n_col = '0;
            n_row = (row_ext + GH_W'(1) >= h_use) ? '0 : row_cur + ROW_W'(1);
        end else begin
            n_col = col_cur + COL_W'(1);
            n_row = (row_ext >= h_use) ? '0 : row_cur;
        end
    end

    always_comb begin
        n_s1.alive   = i_in.cell_alive;
        n_s1.col     = col_cur;
        n_s1.row_out = row_cur - ROW_W'(1);
        n_s1.col_out = col_cur - COL_W'(1);
        n_s1.emit    = (row_cur >= ROW_W'(2)) && (row_ext < h_use)
                    && (col_cur >= COL_W'(2)) && (col_ext < w_use);
        n_s1.last    = (row_ext == h_use - GH_W'(1)) && (col_ext == w_use - GW_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: read at acceptance, write back as stage 1 moves
    // ------------------------------------------------------------------
    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] wr_line;
    logic              r_fwd;
    logic [LINE_W-1:0] r_fwd_data;
    logic              up;
    logic              mid;

    // A read that collides with the same-cycle write gets the new word
    assign line    = r_fwd ? r_fwd_data : ram_rdata;
    assign up      = line[1];
    assign mid     = line[0];
    assign wr_line = {mid, r_s1.alive};

    lags_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1.col),
        .i_wdata (wr_line),
        .i_re    (in_accept),
        .i_raddr (col_cur),
        .o_rdata (ram_rdata)
    );

    // Drop the forward flag once its cell leaves stage 1 with nothing behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_accept) begin
            r_fwd <= s1_move && (col_cur == r_s1.col);
        end else if (s1_move) begin
            r_fwd <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fwd_data <= wr_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= n_s1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: shift the window and apply the rule
    // ------------------------------------------------------------------
    logic [8:0] r_win;
    logic [8:0] n_win;
    logic [3:0] cnt;
    logic       next_alive;

    // newest column enters at the top: bit 6 upper, 7 middle, 8 arriving row
    assign n_win = {r_s1.alive, mid, up, r_win[8:3]};

    always_comb begin
        cnt = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                cnt = cnt + 4'(n_win[i]);
            end
        end
        next_alive = (cnt == 4'd3) || ((cnt == 4'd2) && n_win[4]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_move) begin
            r_win <= n_win;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic             r_next_alive;
    logic [ROW_W-1:0] r_cell_row;
    logic [COL_W-1:0] r_cell_col;
    logic             r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_next_alive <= next_alive;
            r_cell_row   <= r_s1.row_out;
            r_cell_col   <= r_s1.col_out;
            r_last       <= r_s1.last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.next_alive    = r_next_alive;
    assign o_out.cell_row      = r_cell_row;
    assign o_out.cell_col      = r_cell_col;
    assign o_out.last_of_frame = r_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fwd_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forward flag set with stage 1 empty");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1.col) && $stable(r_win)))
        else $error("stalled stage 1 lost its cell or window");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1.emit))
        else $error("result word without an interior cell");

    a_ready_low_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_valid && r_s1.emit && r_out_valid))
        else $error("input blocked without a full output");

endmodule

`default_nettype wire

>>> sv/lags_ram.sv
// ----------------------------------------------------------------------------
// lags_ram - generic simple dual-port RAM
// One write port, one read port, registered read, old data on collision.
// ----------------------------------------------------------------------------
`default_nettype none

module lags_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sim/life_automaton_generation_stream_tb.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_stream_tb - regression for the life generation stream
// Streams padded grids through the block under random back-pressure, predicts
// each interior cell's next B3/S23 state with a local copy of the line stores
// and window, and checks every result word in order against that prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module life_automaton_generation_stream_tb;
    import lags_pkg::*;

    // Run length guard, cycles after the clock starts
    localparam int unsigned CYCLE_LIMIT  = 200000;
    // Cycles to let the pipeline settle once nothing is expected any more
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned TAIL         = 20;
    localparam int unsigned REPORT_MAX   = 10;
    // Total cells to queue before the random phases stop
    localparam int unsigned RANDOM_ITEMS = 1050;
    // Neighbour counts of the B3/S23 rule
    localparam int unsigned BORN_COUNT   = 3;
    localparam int unsigned KEEP_COUNT   = 2;

    typedef struct packed {
        logic alive;
        logic start;
    } raster_word_t;

    typedef struct packed {
        logic             alive;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } gen_word_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    lags_in_if  in_if ();
    lags_out_if out_if ();

    life_automaton_generation_stream u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------------
    raster_word_t raster_q[$];      // cells waiting to be offered
    gen_word_t    next_gen_q[$];    // predicted next-generation words, oldest first
    int unsigned  cells_queued = 0;
    int unsigned  cells_taken  = 0;
    int unsigned  mismatches   = 0;
    int unsigned  cycle_cnt    = 0;

    int unsigned  tx_idle_pct = 36;
    int unsigned  rx_idle_pct = 61;

    // Long receiver hold-off, requested by toggling hold_trig
    int unsigned  hold_len  = 0;
    int unsigned  hold_left = 0;
    bit           hold_trig = 1'b0;
    bit           hold_seen = 1'b0;

    // Local copy of the block's registers and pipeline state
    logic [GW_W-1:0] cfg_width  = GRID_WIDTH_RST;
    logic [GH_W-1:0] cfg_height = GRID_HEIGHT_RST;
    bit              upper_line  [MAX_WIDTH];
    bit              middle_line [MAX_WIDTH];
    logic [8:0]      window  = '0;
    int unsigned     col_cnt = 0;
    int unsigned     row_cnt = 0;

    raster_word_t tx_word;
    gen_word_t    rx_got;
    gen_word_t    rx_exp;

    function automatic void flag(string what);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("%s", what);
    endfunction

    // Widths in use: register value held to the legal range
    function automatic int unsigned eff_width();
        if (cfg_width < GW_MIN) return int'(GW_MIN);
        if (cfg_width > GW_MAX) return int'(GW_MAX);
        return int'(cfg_width);
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height < GH_MIN) return int'(GH_MIN);
        if (cfg_height > GH_MAX) return int'(GH_MAX);
        return int'(cfg_height);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: advance the local grid state by one accepted cell and queue
    // the next state of the interior cell whose lower-right neighbour it is.
    // ------------------------------------------------------------------------
    function automatic void advance_life(logic alive, logic start);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned cnt;
        logic        up;
        logic        mid;
        gen_word_t   res;
        w   = eff_width();
        h   = eff_height();
        up  = 1'b0;
        mid = 1'b0;
        // A start mark pins the cell to the top-left halo corner
        if (start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        r = row_cnt;
        c = col_cnt;
        // Read the two rows above, then shift this column down one row
        if (c < MAX_WIDTH) begin
            up             = upper_line[c];
            mid            = middle_line[c];
            upper_line[c]  = mid;
            middle_line[c] = alive;
        end
        // Newest column enters at the top of the window, lowest row uppermost bit
        window = {alive, mid, up, window[8:3]};
        if (r >= 2 && r < h && c >= 2 && c < w) begin
            cnt       = $countones(window & 9'h1EF);
            res.alive = (cnt == BORN_COUNT) || (cnt == KEEP_COUNT && window[4]);
            res.row   = ROW_W'(r - 1);
            res.col   = COL_W'(c - 1);
            res.last  = (r == h - 1) && (c == w - 1);
            next_gen_q.push_back(res);
        end
        // Wrap at row and frame end; counters left beyond shrunk bounds fold back
        if (c + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
            row_cnt = (r >= h) ? 0 : r;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer queued cells, holding each word until it is taken
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                advance_life(in_if.cell_alive, in_if.frame_start);
                cells_taken++;
            end
            // Only move on once the current word has gone
            if (!in_if.valid || in_if.ready) begin
                if (raster_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    tx_word            = raster_q.pop_front();
                    in_if.cell_alive  <= tx_word.alive;
                    in_if.frame_start <= tx_word.start;
                    in_if.valid       <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver hold-off counter: run down a long stall when asked
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= hold_len;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each taken result word against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                rx_got = '{alive: out_if.next_alive, row: out_if.cell_row,
                           col: out_if.cell_col, last: out_if.last_of_frame};
                if (next_gen_q.size() == 0) begin
                    flag($sformatf("unexpected word: alive %b row %0d col %0d last %b",
                                   rx_got.alive, rx_got.row, rx_got.col, rx_got.last));
                end else begin
                    rx_exp = next_gen_q.pop_front();
                    if (rx_got.alive !== rx_exp.alive || rx_got.row !== rx_exp.row ||
                        rx_got.col !== rx_exp.col || rx_got.last !== rx_exp.last) begin
                        flag($sformatf({"mismatch: expected alive %b row %0d col %0d last %b,",
                                        " got alive %b row %0d col %0d last %b"},
                                       rx_exp.alive, rx_exp.row, rx_exp.col, rx_exp.last,
                                       rx_got.alive, rx_got.row, rx_got.col, rx_got.last));
                    end
                end
            end
            if (hold_left != 0) begin
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Timeout guard
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("life_automaton_generation_stream regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Register access over the APB-style port
    // ------------------------------------------------------------------------
    task automatic read_reg(input t_reg_idx idx, output logic [APB_DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // Access phase ends here with pready high: take the read data
        data    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        logic [APB_DW-1:0] back;
        logic [APB_DW-1:0] want;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // The register takes the word at this edge; mirror it locally
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_GRID_WIDTH) begin
            cfg_width = value[GW_W-1:0];
            want      = APB_DW'(cfg_width);
        end else begin
            cfg_height = value[GH_W-1:0];
            want       = APB_DW'(cfg_height);
        end
        read_reg(idx, back);
        if (back !== want) begin
            flag($sformatf("register %s read back %0h, expected %0h", idx.name(), back, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_cell(input logic alive, input logic start);
        raster_q.push_back('{alive: alive, start: start});
        cells_queued++;
    endtask

    // Raster index i of a 3x3 padded grid carries bit i of the pattern
    task automatic push_pattern(input logic [8:0] pattern, input logic mark);
        for (int i = 0; i < 9; i++) push_cell(pattern[i], mark && i == 0);
    endtask

    // Frames of random content, the last possibly cut short; a frame start now and then breaks a frame
    task automatic send_cells(input int unsigned n, input bit first_mark);
        int unsigned frame_len;
        int unsigned density;
        int unsigned k;
        logic        mark;
        frame_len = eff_width() * eff_height();
        density   = 30;
        for (int unsigned i = 0; i < n; i++) begin
            k = i % frame_len;
            if (k == 0) begin
                case ($urandom_range(9))
                    0:       density = 0;
                    1:       density = 100;
                    default: density = $urandom_range(15, 60);
                endcase
            end
            if (i == 0)      mark = first_mark;
            else if (k == 0) mark = $urandom_range(1);
            else             mark = ($urandom_range(199) == 0);
            push_cell($urandom_range(99) < density, mark);
        end
    endtask

    // Wait until every cell is taken and every prediction has been met
    task automatic wait_quiet();
        do @(negedge clk);
        while (cells_taken != cells_queued || next_gen_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // New register setting once idle, then a stream under it
    task automatic run_phase(input int unsigned w, input int unsigned h,
                             input int unsigned n, input bit first_mark);
        wait_quiet();
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        send_cells(n, first_mark);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned n;
        do @(negedge clk);
        while (!rst_n);

        // Directed: smallest grid, one interior cell per frame
        write_reg(REG_GRID_WIDTH, 3);
        write_reg(REG_GRID_HEIGHT, 3);
        push_pattern(9'b000_000_111, 1'b1);   // dead centre, three neighbours: born
        push_pattern(9'b000_111_000, 1'b0);   // follow-on frame, live centre, two: kept
        for (int i = 0; i < 7; i++) push_cell(1'b1, i == 0);   // cut short by the next phase

        // Receiver stalls more often than the sender idles first, the other way round later
        run_phase(5, 4, 150, 1'b1);
        run_phase(0, 2, 90, 1'b1);            // both below range: held at the minimum

        // Stall the receiver for a long stretch while cells keep coming
        wait_quiet();
        write_reg(REG_GRID_WIDTH, 8);
        write_reg(REG_GRID_HEIGHT, 6);
        hold_len  = 400;
        hold_trig = ~hold_trig;
        send_cells(120, 1'b1);

        // Swap the idling of the two sides
        wait_quiet();
        tx_idle_pct = 61;
        rx_idle_pct = 36;
        // Shrink the grid in the middle of a frame and carry on without a mark
        run_phase(12, 9, 60, 1'b1);
        run_phase(5, 4, 100, 1'b0);
        run_phase(3, 8191, 90, 1'b1);         // tallest setting, held at the maximum
        run_phase(1024, 4096, 30, 1'b1);      // exact upper bounds, no interior reached

        // Neither side idles from here
        wait_quiet();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(2047, 3, 60, 1'b1);         // widest setting, held at the maximum

        // Sender pause: stop until every word has come back, then resume without a mark
        run_phase(7, 5, 70, 1'b1);
        wait_quiet();
        send_cells(70, 1'b0);

        // Random settings on small grids until the cell count is reached
        while (cells_queued < RANDOM_ITEMS) begin
            n = $urandom_range(40, 120);
            run_phase($urandom_range(0, 16), $urandom_range(0, 10), n, 1'b1);
        end

        // Drain, then allow the pipeline to show any stray word
        wait_quiet();
        repeat (TAIL) @(negedge clk);
        if (next_gen_q.size() != 0) begin
            flag($sformatf("%0d predicted words never arrived", next_gen_q.size()));
        end
        if (mismatches == 0) begin
            $display("life_automaton_generation_stream regression: pass");
        end else begin
            $display("life_automaton_generation_stream regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
sv/lags_pkg.sv
sv/lags_in_if.sv
sv/lags_out_if.sv
sv/lags_ram.sv
sv/life_automaton_generation_stream.sv
sim/life_automaton_generation_stream_tb.sv
